// ===== rtl/core/rotated_region_pixel_packer_assert.svh =====
// Assertion macros shared by the rotated region pixel packer RTL.
// Expects clk and rst_n in the scope of the including module.
`ifndef ROTATED_REGION_PIXEL_PACKER_ASSERT_SVH
`define ROTATED_REGION_PIXEL_PACKER_ASSERT_SVH

// same-cycle implication
`define RRPP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RRPP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rrpp_pkg.sv =====
// Package for the rotated region pixel packer: types, codes and defaults.
// No dependencies.
package rrpp_pkg;

    localparam int HOR_PIXELS_DEF = 256;
    localparam int VER_PIXELS_DEF = 256;

    localparam int BYTE_ADDR_W = 14;
    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 32;

    localparam logic [2:0] REG_ORIENTATION   = 3'd0;
    localparam logic [2:0] REG_REGION_X      = 3'd1;
    localparam logic [2:0] REG_REGION_Y      = 3'd2;
    localparam logic [2:0] REG_REGION_WIDTH  = 3'd3;
    localparam logic [2:0] REG_REGION_HEIGHT = 3'd4;

    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    localparam logic [1:0] CODE_ON    = 2'h2;
    localparam logic [1:0] CODE_OFF   = 2'h1;
    localparam logic [7:0] RESET_FILL = 8'h55;

    typedef struct packed {
        logic [1:0] orientation;
        logic [7:0] region_x;
        logic [7:0] region_y;
        logic [8:0] region_width;
        logic [8:0] region_height;
    } cfg_t;

    typedef struct packed {
        logic       dropped;
        logic       done;
        logic       pixel_on;
        logic [1:0] lane;
    } cmd_t;

    typedef struct packed {
        logic [BYTE_ADDR_W-1:0] byte_address;
        logic [7:0]             byte_value;
        logic                   dropped;
        logic                   region_done;
    } res_t;

endpackage

// ===== rtl/core/rrpp_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module rrpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/rrpp_fifo.sv =====
// Small first-word-fall-through queue built from flops.
// No dependencies.
module rrpp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNW-1:0]   count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/core/rrpp_front.sv =====
// Front end: region counters, rotation, clipping and byte address generation.
// Depends on rrpp_pkg and the assertion macro header.
`include "rotated_region_pixel_packer_assert.svh"
module rrpp_front #(
    parameter int HOR_PIXELS = rrpp_pkg::HOR_PIXELS_DEF,
    parameter int VER_PIXELS = rrpp_pkg::VER_PIXELS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rrpp_pkg::cfg_t      cfg,
    input  logic                accept,
    input  logic                pixel_on,
    output logic                stall,
    output logic                cmd_push,
    output rrpp_pkg::cmd_t      cmd,
    output logic [((((HOR_PIXELS + 3) / 4) * VER_PIXELS) > 1 ?
                   $clog2(((HOR_PIXELS + 3) / 4) * VER_PIXELS) : 1)-1:0] cmd_addr,
    input  logic                cmd_full
);

    localparam int LINE_BYTES  = (HOR_PIXELS + 3) / 4;
    localparam int STORE_BYTES = LINE_BYTES * VER_PIXELS;
    localparam int AW  = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int DXW = $clog2(HOR_PIXELS);
    localparam int DYW = (VER_PIXELS > 1) ? $clog2(VER_PIXELS) : 1;
    localparam int MAXP = (HOR_PIXELS > VER_PIXELS) ? HOR_PIXELS : VER_PIXELS;
    localparam int PW  = $clog2(MAXP);
    localparam int CW  = ((PW > 10) ? PW : 10) + 1;

    localparam logic signed [CW-1:0] HM1 = CW'(HOR_PIXELS - 1);
    localparam logic signed [CW-1:0] VM1 = CW'(VER_PIXELS - 1);
    localparam logic [AW-1:0] LINE_B = AW'(LINE_BYTES);

    logic [8:0] col_reg, col_next;
    logic [8:0] row_reg, row_next;
    logic [8:0] w_eff, h_eff;
    logic [9:0] col_inc, row_inc;
    logic       col_wrap, row_wrap, done_now;

    logic       s1_v_reg;
    logic [9:0] s1_lx_reg, s1_ly_reg;
    logic [1:0] s1_rot_reg;
    logic       s1_on_reg, s1_done_reg;

    logic           s2_v_reg;
    logic [DXW-1:0] s2_dx_reg;
    logic [DYW-1:0] s2_dy_reg;
    logic           s2_drop_reg, s2_on_reg, s2_done_reg;

    logic                 s1_free, s2_free, s1_move;
    logic signed [CW-1:0] slx, sly, dx_s, dy_s;
    logic                 drop_now;

    assign w_eff    = (cfg.region_width == '0) ? 9'd1 : cfg.region_width;
    assign h_eff    = (cfg.region_height == '0) ? 9'd1 : cfg.region_height;
    assign col_inc  = {1'b0, col_reg} + 10'd1;
    assign row_inc  = {1'b0, row_reg} + 10'd1;
    assign col_wrap = (col_inc >= {1'b0, w_eff});
    assign row_wrap = (row_inc >= {1'b0, h_eff});
    assign done_now = col_wrap && row_wrap;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            col_next = col_wrap ? '0 : col_inc[8:0];
            if (col_wrap)
            begin
                row_next = row_wrap ? '0 : row_inc[8:0];
            end
        end
    end

    assign s2_free = !s2_v_reg || !cmd_full;
    assign s1_move = s1_v_reg && s2_free;
    assign s1_free = !s1_v_reg || s2_free;
    assign stall   = !s1_free;

    assign slx = signed'(CW'(s1_lx_reg));
    assign sly = signed'(CW'(s1_ly_reg));

    always_comb
    begin
        unique case (s1_rot_reg)
            rrpp_pkg::ROT_0:
            begin
                dx_s = slx;
                dy_s = sly;
            end
            rrpp_pkg::ROT_90:
            begin
                dx_s = HM1 - sly;
                dy_s = slx;
            end
            rrpp_pkg::ROT_180:
            begin
                dx_s = HM1 - slx;
                dy_s = VM1 - sly;
            end
            rrpp_pkg::ROT_270:
            begin
                dx_s = sly;
                dy_s = VM1 - slx;
            end
        endcase
    end

    assign drop_now = (dx_s < 0) || (dy_s < 0) || (dx_s > HM1) || (dy_s > VM1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (s1_free)
            begin
                s1_v_reg <= accept;
            end
            if (s2_free)
            begin
                s2_v_reg <= s1_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_lx_reg   <= {2'b00, cfg.region_x} + {1'b0, col_reg};
            s1_ly_reg   <= {2'b00, cfg.region_y} + {1'b0, row_reg};
            s1_rot_reg  <= cfg.orientation;
            s1_on_reg   <= pixel_on;
            s1_done_reg <= done_now;
        end
        if (s1_move)
        begin
            s2_dx_reg   <= DXW'(dx_s);
            s2_dy_reg   <= DYW'(dy_s);
            s2_drop_reg <= drop_now;
            s2_on_reg   <= s1_on_reg;
            s2_done_reg <= s1_done_reg;
        end
    end

    assign cmd_push     = s2_v_reg;
    assign cmd.dropped  = s2_drop_reg;
    assign cmd.done     = s2_done_reg;
    assign cmd.pixel_on = s2_on_reg;
    assign cmd.lane     = s2_dx_reg[1:0];
    assign cmd_addr     = AW'(s2_dy_reg) * LINE_B + AW'(s2_dx_reg >> 2);

    `RRPP_ASSERT_NXT(a_front_wrap, accept && done_now, (col_reg == '0) && (row_reg == '0),
        "region counters did not return to zero at end of region")
    `RRPP_ASSERT_NXT(a_front_hold, s2_v_reg && cmd_full, s2_v_reg && $stable(s2_dx_reg),
        "front stage lost a transaction while the queue was full")

endmodule

// ===== rtl/core/rrpp_back.sv =====
// Back end: framebuffer read-modify-write with forwarding, clear pass, result queue.
// Depends on rrpp_pkg, rrpp_ram, rrpp_fifo and the assertion macro header.
`include "rotated_region_pixel_packer_assert.svh"
module rrpp_back #(
    parameter int HOR_PIXELS = rrpp_pkg::HOR_PIXELS_DEF,
    parameter int VER_PIXELS = rrpp_pkg::VER_PIXELS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    output logic                clear_busy,
    input  logic                cmd_empty,
    output logic                cmd_pop,
    input  rrpp_pkg::cmd_t      cmd,
    input  logic [((((HOR_PIXELS + 3) / 4) * VER_PIXELS) > 1 ?
                   $clog2(((HOR_PIXELS + 3) / 4) * VER_PIXELS) : 1)-1:0] cmd_addr,
    output logic                res_empty,
    input  logic                res_pop,
    output rrpp_pkg::res_t      res
);

    localparam int LINE_BYTES  = (HOR_PIXELS + 3) / 4;
    localparam int STORE_BYTES = LINE_BYTES * VER_PIXELS;
    localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int RW = $bits(rrpp_pkg::res_t);
    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);

    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;

    logic           b2_v_reg;
    rrpp_pkg::cmd_t b2_cmd_reg;
    logic [AW-1:0]  b2_addr_reg;

    logic          fwd_v_reg;
    logic [AW-1:0] fwd_addr_reg;
    logic [7:0]    fwd_data_reg;

    logic          res_full, res_push, b2_free, item_we;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata, ram_rdata, cur_byte, merged;
    logic [1:0]    code;
    rrpp_pkg::res_t res_in;
    logic [RW-1:0]  res_q;

    assign clear_busy = clr_busy_reg;
    assign b2_free    = !b2_v_reg || !res_full;
    assign cmd_pop    = !cmd_empty && b2_free && !clr_busy_reg;
    assign res_push   = b2_v_reg && !res_full;
    assign item_we    = res_push && !b2_cmd_reg.dropped;

    assign cur_byte = (fwd_v_reg && (fwd_addr_reg == b2_addr_reg)) ? fwd_data_reg : ram_rdata;
    assign code     = b2_cmd_reg.pixel_on ? rrpp_pkg::CODE_ON : rrpp_pkg::CODE_OFF;

    always_comb
    begin
        merged = cur_byte;
        unique case (b2_cmd_reg.lane)
            2'd0: merged[7:6] = code;
            2'd1: merged[5:4] = code;
            2'd2: merged[3:2] = code;
            2'd3: merged[1:0] = code;
        endcase
    end

    assign ram_we    = clr_busy_reg || item_we;
    assign ram_waddr = clr_busy_reg ? clr_addr_reg : b2_addr_reg;
    assign ram_wdata = clr_busy_reg ? rrpp_pkg::RESET_FILL : merged;

    rrpp_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd_pop),
        .raddr (cmd_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            b2_v_reg     <= 1'b0;
            fwd_v_reg    <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (b2_free)
            begin
                b2_v_reg <= cmd_pop;
            end
            if (ram_we)
            begin
                fwd_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            b2_cmd_reg  <= cmd;
            b2_addr_reg <= cmd_addr;
        end
        if (ram_we)
        begin
            fwd_addr_reg <= ram_waddr;
            fwd_data_reg <= ram_wdata;
        end
    end

    assign res_in.byte_address = b2_cmd_reg.dropped ? '0 : rrpp_pkg::BYTE_ADDR_W'(b2_addr_reg);
    assign res_in.byte_value   = b2_cmd_reg.dropped ? '0 : merged;
    assign res_in.dropped      = b2_cmd_reg.dropped;
    assign res_in.region_done  = b2_cmd_reg.done;

    rrpp_fifo #(
        .WIDTH (RW),
        .DEPTH (2)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (res_pop),
        .rdata (res_q),
        .empty (res_empty)
    );

    assign res = rrpp_pkg::res_t'(res_q);

    `RRPP_ASSERT_IMP(a_back_clear_blocks, clr_busy_reg, !cmd_pop,
        "transaction issued during framebuffer clear")
    `RRPP_ASSERT_IMP(a_back_clear_len, $fell(clr_busy_reg), $past(clr_addr_reg) == LAST_ADDR,
        "framebuffer clear ended before the last byte")
    `RRPP_ASSERT_NXT(a_back_hold, b2_v_reg && res_full, b2_v_reg && $stable(b2_addr_reg),
        "read-modify-write stage changed while stalled")

endmodule

// ===== rtl/core/rotated_region_pixel_packer.sv =====
// Top level of the rotated region pixel packer: APB registers and block wiring.
// Depends on rrpp_pkg, rrpp_front, rrpp_fifo and rrpp_back.
//
// Accepts one 1-bit pixel per clock while full is low and returns one result per
// pixel, in order. Each pixel walks the configured region in row-major order, is
// rotated into display coordinates and written as a 2-bit code into a packed
// framebuffer (four pixels per byte, first pixel in bits 7:6) held in one simple
// dual-port RAM; the read-modify-write forwards the last written byte, so
// back-to-back pixels in the same byte sustain one pixel per clock. After reset
// the framebuffer is filled with 0x55, one byte per clock, through all
// ceil(HOR_PIXELS/4)*VER_PIXELS bytes (16384 at the defaults), while full stays
// high; register writes are taken throughout. Registers sit at byte offsets 0x0
// orientation, 0x4 region_x, 0x8 region_y, 0xC region_width, 0x10 region_height.
module rotated_region_pixel_packer #(
    parameter int HOR_PIXELS = rrpp_pkg::HOR_PIXELS_DEF,
    parameter int VER_PIXELS = rrpp_pkg::VER_PIXELS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rrpp_pkg::PADDR_W-1:0]     paddr,
    input  logic [rrpp_pkg::PDATA_W-1:0]     pwdata,
    output logic [rrpp_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready,
    input  logic                             push,
    output logic                             full,
    input  logic                             pixel_on,
    output logic                             empty,
    input  logic                             pop,
    output logic [rrpp_pkg::BYTE_ADDR_W-1:0] byte_address,
    output logic [7:0]                       byte_value,
    output logic                             dropped,
    output logic                             region_done
);

    localparam int LINE_BYTES  = (HOR_PIXELS + 3) / 4;
    localparam int STORE_BYTES = LINE_BYTES * VER_PIXELS;
    localparam int AW   = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int CMDW = $bits(rrpp_pkg::cmd_t);
    localparam int QW   = AW + CMDW;

    logic [1:0] orientation_reg;
    logic [7:0] region_x_reg;
    logic [7:0] region_y_reg;
    logic [8:0] region_width_reg;
    logic [8:0] region_height_reg;

    logic           cfg_wr;
    logic [2:0]     reg_idx;
    rrpp_pkg::cfg_t cfg;

    logic           accept, front_stall, clear_busy;
    logic           fcmd_push, q_full, q_empty, q_pop;
    rrpp_pkg::cmd_t fcmd, qcmd;
    logic [AW-1:0]  fcmd_addr, qcmd_addr;
    logic [QW-1:0]  q_wdata, q_rdata;
    rrpp_pkg::res_t res;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orientation_reg   <= rrpp_pkg::ROT_0;
            region_x_reg      <= '0;
            region_y_reg      <= '0;
            region_width_reg  <= 9'd1;
            region_height_reg <= 9'd1;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                rrpp_pkg::REG_ORIENTATION:   orientation_reg   <= pwdata[1:0];
                rrpp_pkg::REG_REGION_X:      region_x_reg      <= pwdata[7:0];
                rrpp_pkg::REG_REGION_Y:      region_y_reg      <= pwdata[7:0];
                rrpp_pkg::REG_REGION_WIDTH:  region_width_reg  <= pwdata[8:0];
                rrpp_pkg::REG_REGION_HEIGHT: region_height_reg <= pwdata[8:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            rrpp_pkg::REG_ORIENTATION:   prdata = rrpp_pkg::PDATA_W'(orientation_reg);
            rrpp_pkg::REG_REGION_X:      prdata = rrpp_pkg::PDATA_W'(region_x_reg);
            rrpp_pkg::REG_REGION_Y:      prdata = rrpp_pkg::PDATA_W'(region_y_reg);
            rrpp_pkg::REG_REGION_WIDTH:  prdata = rrpp_pkg::PDATA_W'(region_width_reg);
            rrpp_pkg::REG_REGION_HEIGHT: prdata = rrpp_pkg::PDATA_W'(region_height_reg);
            default:                     prdata = '0;
        endcase
    end

    assign cfg.orientation   = orientation_reg;
    assign cfg.region_x      = region_x_reg;
    assign cfg.region_y      = region_y_reg;
    assign cfg.region_width  = region_width_reg;
    assign cfg.region_height = region_height_reg;

    assign full   = front_stall || clear_busy;
    assign accept = push && !full;

    rrpp_front #(
        .HOR_PIXELS (HOR_PIXELS),
        .VER_PIXELS (VER_PIXELS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .accept   (accept),
        .pixel_on (pixel_on),
        .stall    (front_stall),
        .cmd_push (fcmd_push),
        .cmd      (fcmd),
        .cmd_addr (fcmd_addr),
        .cmd_full (q_full)
    );

    assign q_wdata = {fcmd_addr, fcmd};

    rrpp_fifo #(
        .WIDTH (QW),
        .DEPTH (4)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fcmd_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    assign qcmd_addr = q_rdata[QW-1:CMDW];
    assign qcmd      = rrpp_pkg::cmd_t'(q_rdata[CMDW-1:0]);

    rrpp_back #(
        .HOR_PIXELS (HOR_PIXELS),
        .VER_PIXELS (VER_PIXELS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear_busy (clear_busy),
        .cmd_empty  (q_empty),
        .cmd_pop    (q_pop),
        .cmd        (qcmd),
        .cmd_addr   (qcmd_addr),
        .res_empty  (empty),
        .res_pop    (pop),
        .res        (res)
    );

    assign byte_address = res.byte_address;
    assign byte_value   = res.byte_value;
    assign dropped      = res.dropped;
    assign region_done  = res.region_done;

endmodule

// ===== tb/rotated_region_pixel_packer_test.sv =====
// Self-checking testbench for rotated_region_pixel_packer: predicts every framebuffer
// byte update from a local image of the framebuffer and checks results in order.
// Depends on rrpp_pkg and the rotated_region_pixel_packer RTL.
`timescale 1ns / 100ps

module rotated_region_pixel_packer_test;
    import rrpp_pkg::*;

    localparam int HOR_PIXELS    = HOR_PIXELS_DEF;
    localparam int VER_PIXELS    = VER_PIXELS_DEF;
    localparam int LINE_BYTES    = (HOR_PIXELS + 3) / 4;
    localparam int IMAGE_BYTES   = LINE_BYTES * VER_PIXELS;
    localparam int RANDOM_PIXELS = 2000;
    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int MAX_PRINTED   = 40;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PADDR_W-1:0]     paddr = '0;
    logic [PDATA_W-1:0]     pwdata = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;
    logic                   push = 1'b0;
    logic                   full;
    logic                   pixel_on = 1'b0;
    logic                   empty;
    logic                   pop = 1'b0;
    logic [BYTE_ADDR_W-1:0] byte_address;
    logic [7:0]             byte_value;
    logic                   dropped;
    logic                   region_done;

    // testbench view of the block
    cfg_t       region_cfg;
    logic [7:0] frame_image [IMAGE_BYTES];
    int         col_count;
    int         row_count;

    logic pixel_q [$];
    res_t predicted_updates [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int error_count = 0;
    int cycle_count = 0;

    rotated_region_pixel_packer #(
        .HOR_PIXELS(HOR_PIXELS),
        .VER_PIXELS(VER_PIXELS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .push        (push),
        .full        (full),
        .pixel_on    (pixel_on),
        .empty       (empty),
        .pop         (pop),
        .byte_address(byte_address),
        .byte_value  (byte_value),
        .dropped     (dropped),
        .region_done (region_done)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic note_mismatch(string msg);
        if (error_count < MAX_PRINTED)
            $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    // rotate, pack and read-modify-write one pixel; advance the region walk
    function automatic res_t paint_pixel(logic on);
        int         lx;
        int         ly;
        int         dx;
        int         dy;
        int         wd;
        int         ht;
        int         addr;
        int         sh;
        logic [7:0] mask;
        logic [7:0] code_bits;
        res_t       upd;

        lx = int'(region_cfg.region_x) + col_count;
        ly = int'(region_cfg.region_y) + row_count;
        wd = (region_cfg.region_width == 0) ? 1 : int'(region_cfg.region_width);
        ht = (region_cfg.region_height == 0) ? 1 : int'(region_cfg.region_height);
        case (region_cfg.orientation)
            ROT_0:
            begin
                dx = lx;
                dy = ly;
            end
            ROT_90:
            begin
                dx = HOR_PIXELS - 1 - ly;
                dy = lx;
            end
            ROT_180:
            begin
                dx = HOR_PIXELS - 1 - lx;
                dy = VER_PIXELS - 1 - ly;
            end
            default:
            begin
                dx = ly;
                dy = VER_PIXELS - 1 - lx;
            end
        endcase

        upd = '0;
        if (dx < 0 || dy < 0 || dx >= HOR_PIXELS || dy >= VER_PIXELS)
        begin
            upd.dropped = 1'b1;
        end
        else
        begin
            addr = dy * LINE_BYTES + dx / 4;
            sh = 6 - 2 * (dx % 4);
            mask = 8'h03 << sh;
            code_bits = 8'(on ? CODE_ON : CODE_OFF) << sh;
            frame_image[addr] = (frame_image[addr] & ~mask) | (code_bits & mask);
            upd.byte_address = addr[BYTE_ADDR_W-1:0];
            upd.byte_value = frame_image[addr];
        end

        col_count++;
        if (col_count >= wd)
        begin
            col_count = 0;
            row_count++;
            if (row_count >= ht)
            begin
                row_count = 0;
                upd.region_done = 1'b1;
            end
        end
        return upd;
    endfunction

    function automatic void apply_register(logic [2:0] index, logic [PDATA_W-1:0] value);
        case (index)
            REG_ORIENTATION:   region_cfg.orientation = value[1:0];
            REG_REGION_X:      region_cfg.region_x = value[7:0];
            REG_REGION_Y:      region_cfg.region_y = value[7:0];
            REG_REGION_WIDTH:  region_cfg.region_width = value[8:0];
            REG_REGION_HEIGHT: region_cfg.region_height = value[8:0];
            default: ;
        endcase
    endfunction

    // driver: offers queued pixels, holds push while full
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            pixel_on <= 1'b0;
        end
        else
        begin
            if (push && !full)
                predicted_updates.push_back(paint_pixel(pixel_on));
            if (!(push && full))
            begin
                if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    push <= 1'b1;
                    pixel_on <= pixel_q.pop_front();
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // monitor: pops results and checks them against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (predicted_updates.size() == 0)
                begin
                    note_mismatch($sformatf("unexpected transaction addr=%0d value=%02h",
                                            byte_address, byte_value));
                end
                else
                begin
                    want = predicted_updates.pop_front();
                    if (byte_address !== want.byte_address)
                        note_mismatch($sformatf("byte_address %0d, expected %0d",
                                                byte_address, want.byte_address));
                    if (byte_value !== want.byte_value)
                        note_mismatch($sformatf("byte_value %02h, expected %02h at addr %0d",
                                                byte_value, want.byte_value, want.byte_address));
                    if (dropped !== want.dropped)
                        note_mismatch($sformatf("dropped %b, expected %b",
                                                dropped, want.dropped));
                    if (region_done !== want.region_done)
                        note_mismatch($sformatf("region_done %b, expected %b",
                                                region_done, want.region_done));
                end
            end
            pop <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_register(logic [2:0] index, logic [PDATA_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        apply_register(index, value);
    endtask

    // upper bits carry noise; the block keeps only the field width
    task automatic program_region(logic [1:0] o, logic [7:0] x, logic [7:0] y,
                                  logic [8:0] w, logic [8:0] h);
        write_register(REG_ORIENTATION, ($urandom() << 2) | 32'(o));
        write_register(REG_REGION_X, ($urandom() << 8) | 32'(x));
        write_register(REG_REGION_Y, ($urandom() << 8) | 32'(y));
        write_register(REG_REGION_WIDTH, ($urandom() << 9) | 32'(w));
        write_register(REG_REGION_HEIGHT, ($urandom() << 9) | 32'(h));
    endtask

    task automatic wait_idle();
        while (pixel_q.size() != 0 || push || predicted_updates.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic queue_pixels(int count);
        repeat (count) pixel_q.push_back(1'($urandom_range(1)));
    endtask

    function automatic logic [7:0] pick_offset();
        case ($urandom_range(3))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [8:0] pick_extent();
        int sel;
        sel = $urandom_range(99);
        if (sel < 50) return 9'($urandom_range(1, 8));
        if (sel < 62) return 9'd256;
        if (sel < 72) return 9'd0;
        if (sel < 82) return 9'($urandom_range(257, 511));
        return 9'($urandom_range(1, 255));
    endfunction

    initial
    begin : stimulus
        int         sent;
        int         phase_idx;
        int         count;
        int         area;
        logic [8:0] w;
        logic [8:0] h;

        for (int i = 0; i < IMAGE_BYTES; i++)
            frame_image[i] = RESET_FILL;
        region_cfg = '0;
        region_cfg.region_width = 9'd1;
        region_cfg.region_height = 9'd1;
        col_count = 0;
        row_count = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: two pixels into byte 0
        pixel_q.push_back(1'b1);
        pixel_q.push_back(1'b0);
        wait_idle();

        // 90 degrees at the far corner, partly off display
        program_region(ROT_90, 8'd255, 8'd255, 9'd2, 9'd2);
        pixel_q = '{1'b0, 1'b1, 1'b1, 1'b0};
        wait_idle();

        // zero extents act as one; 180 degrees hits the last byte
        program_region(ROT_180, 8'd0, 8'd0, 9'd0, 9'd0);
        pixel_q = '{1'b1, 1'b0};
        wait_idle();

        // 270 degrees running off the top
        program_region(ROT_270, 8'd254, 8'd3, 9'd3, 9'd1);
        pixel_q = '{1'b1, 1'b1, 1'b0};
        wait_idle();

        // leave the walk mid-region, then shrink it under the counters
        program_region(ROT_0, 8'd10, 8'd20, 9'd4, 9'd4);
        queue_pixels(11);
        wait_idle();
        program_region(ROT_0, 8'd10, 8'd20, 9'd2, 9'd2);
        queue_pixels(2);
        wait_idle();

        // unmapped register offsets are ignored
        for (int i = int'(REG_REGION_HEIGHT) + 1; i < (1 << (PADDR_W - 2)); i++)
            write_register(3'(i), $urandom());
        queue_pixels(2);
        wait_idle();

        sent = 0;
        phase_idx = 0;
        while (sent < RANDOM_PIXELS)
        begin
            w = pick_extent();
            h = pick_extent();
            program_region(2'($urandom_range(3)), pick_offset(), pick_offset(), w, h);
            @(negedge clk);
            case (phase_idx % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 71;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 71;
                end
                default:
                begin
                    send_idle_pct = 13;
                    recv_stall_pct = 13;
                end
            endcase
            area = ((w == 0) ? 1 : int'(w)) * ((h == 0) ? 1 : int'(h));
            if (phase_idx == 4)
            begin
                hold_left = HOLD_CYCLES;
                count = 400;
            end
            else if ($urandom_range(3) != 0 && area <= 200)
            begin
                count = area * $urandom_range(1, 200 / area);
            end
            else
            begin
                count = $urandom_range(1, 150);
            end
            queue_pixels(count);
            sent += count;
            wait_idle();
            phase_idx++;
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
